>>> hw/rtl/cached_slot_id_allocator_assert.svh
// assertion macros for the slot id allocator
`ifndef CACHED_SLOT_ID_ALLOCATOR_ASSERT_SVH
`define CACHED_SLOT_ID_ALLOCATOR_ASSERT_SVH

// checked on every edge outside reset
`define CSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/csa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package csa_pkg;

    localparam int SLOT_W     = 10;
    localparam int SLOT_COUNT = 1024;
    localparam int MAP_WORD_W = 32;
    localparam int MAP_WORDS  = SLOT_COUNT / MAP_WORD_W;
    localparam int BIT_IDX_W  = $clog2(MAP_WORD_W);
    localparam int MAP_IDX_W  = $clog2(MAP_WORDS);
    localparam int ST_W       = 2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SLOT = 2'd1;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd2;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_REFILL_CHK,
        S_TAKE_RD,
        S_TAKE_WR,
        S_POP,
        S_DRAIN_RD,
        S_DRAIN_WR,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic            clr_step;
        logic            cap;
        logic            wipe;
        logic            take_rd;
        logic            take_wr;
        logic            give_rd;
        logic            give_wr;
        logic            pop;
        logic            push;
        logic            fin;
        logic [ST_W-1:0] fin_code;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_add;
        logic slot_zero;
        logic cnt_zero;
        logic cnt_full;
        logic refill_more;
        logic drain_more;
        logic map_full;
    } t_dp_stat;

    // lowest clear bit of a map word
    function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [MAP_WORD_W-1:0] w);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cached_slot_id_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake               beat
// command   in         i_start with o_busy low i_action, i_item_value, i_slot_index
// result    out        o_done, one cycle       o_status, o_slot_out
//
// add with ids in the cache: the top id is popped from the cache and returned
// add with an empty cache: ids are first gathered from the bitmap (16 at most)
// remove: the id is pushed to the cache; with the cache full 17 ids are first returned
// each id gathered or returned is a read-modify-write on the bitmap word memory
// after reset a clearing pass over all 1024 slots zeroes the slot table, o_busy high
// results cannot be stalled; o_done lasts one cycle and a new command may start then
module cached_slot_id_allocator #(
    parameter int CACHE_DEPTH = 31,
    parameter int ITEM_WIDTH  = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_action,
    input  logic [ITEM_WIDTH-1:0]      i_item_value,
    input  logic [csa_pkg::SLOT_W-1:0] i_slot_index,
    output logic                       o_done,
    output logic [csa_pkg::ST_W-1:0]   o_status,
    output logic [csa_pkg::SLOT_W-1:0] o_slot_out
);
    import csa_pkg::*;

    // controller drives commands, datapath answers with status flags
    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    csa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    // cache stack, bitmap words, slot table and the result register
    csa_dpath #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_action     (i_action),
        .i_item_value (i_item_value),
        .i_slot_index (i_slot_index),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out)
    );

`include "cached_slot_id_allocator_assert.svh"

    // one result per command, never two strobes in a row
    `CSA_ASSERT_ALWAYS(a_done_single, o_done |=> !o_done, "result strobe held two cycles")
    // a failed add reports no slot
    `CSA_ASSERT(a_fail_no_slot, (o_done && o_status == ST_NO_SLOT) |-> (o_slot_out == '0), "failed add gave a slot")
    // no cache or bitmap update while idle
    `CSA_ASSERT(a_idle_quiet, !o_busy |-> !(w_cmd.pop || w_cmd.push || w_cmd.take_wr || w_cmd.give_wr), "update while idle")
    // shortage is only reported with every bitmap word full
    `CSA_ASSERT(a_fail_map_full, (w_cmd.fin && w_cmd.fin_code == ST_NO_SLOT) |-> w_stat.map_full, "shortage with free ids")

endmodule
`default_nettype wire

>>> hw/rtl/csa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module csa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule
`default_nettype wire

>>> hw/rtl/csa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module csa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  csa_pkg::t_dp_stat i_stat,
    output csa_pkg::t_ctl_cmd o_cmd,
    output logic              o_busy
);
    import csa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_stat.is_add) begin
                    n_state = i_stat.cnt_zero ? S_REFILL_CHK : S_POP;
                end else if (i_stat.slot_zero) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = i_stat.cnt_full ? S_DRAIN_RD : S_PUSH;
                end
            end
            S_REFILL_CHK: begin
                priority if (!i_stat.refill_more) begin
                    n_state = S_POP;
                end else if (i_stat.map_full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_TAKE_RD;
                end
            end
            S_TAKE_RD:  n_state = S_TAKE_WR;
            S_TAKE_WR:  n_state = S_REFILL_CHK;
            S_POP:      n_state = S_IDLE;
            S_DRAIN_RD: n_state = i_stat.drain_more ? S_DRAIN_WR : S_PUSH;
            S_DRAIN_WR: n_state = S_DRAIN_RD;
            S_PUSH:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE:  o_cmd.cap = i_start;
            S_EVAL: begin
                if (!i_stat.is_add) begin
                    if (i_stat.slot_zero) begin
                        o_cmd.fin      = 1'b1;
                        o_cmd.fin_code = ST_IGNORED;
                    end else begin
                        o_cmd.wipe = 1'b1;
                    end
                end
            end
            S_REFILL_CHK: begin
                if (i_stat.refill_more && i_stat.map_full) begin
                    o_cmd.fin      = 1'b1;
                    o_cmd.fin_code = ST_NO_SLOT;
                end
            end
            S_TAKE_RD: o_cmd.take_rd = 1'b1;
            S_TAKE_WR: o_cmd.take_wr = 1'b1;
            S_POP: begin
                o_cmd.pop      = 1'b1;
                o_cmd.fin      = 1'b1;
                o_cmd.fin_code = ST_OK;
            end
            S_DRAIN_RD: o_cmd.give_rd = i_stat.drain_more;
            S_DRAIN_WR: o_cmd.give_wr = 1'b1;
            S_PUSH: begin
                o_cmd.push     = 1'b1;
                o_cmd.fin      = 1'b1;
                o_cmd.fin_code = ST_OK;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> hw/rtl/csa_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module csa_dpath #(
    parameter int CACHE_DEPTH = 31,
    parameter int ITEM_WIDTH  = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  csa_pkg::t_ctl_cmd          i_cmd,
    output csa_pkg::t_dp_stat          o_stat,
    input  logic                       i_action,
    input  logic [ITEM_WIDTH-1:0]      i_item_value,
    input  logic [csa_pkg::SLOT_W-1:0] i_slot_index,
    output logic                       o_done,
    output logic [csa_pkg::ST_W-1:0]   o_status,
    output logic [csa_pkg::SLOT_W-1:0] o_slot_out
);
    import csa_pkg::*;

    localparam int CW = $clog2(CACHE_DEPTH + 1);
    localparam int IW = $clog2(CACHE_DEPTH);

    logic                  r_action;
    logic [ITEM_WIDTH-1:0] r_item;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W-1:0]     r_id;
    logic [CW-1:0]         r_count;
    logic [SLOT_W-1:0]     r_cache [CACHE_DEPTH];
    logic [MAP_IDX_W-1:0]  r_widx;
    logic [MAP_WORDS-1:0]  r_full;
    logic [MAP_WORDS-1:0]  r_wvalid;
    logic [SLOT_W-1:0]     r_clr;

    logic [CW-1:0]         w_cnt_dec;
    logic [SLOT_W-1:0]     w_top;
    logic [MAP_IDX_W-1:0]  w_rd_widx;
    logic [MAP_WORD_W-1:0] w_map_q;
    logic [MAP_WORD_W-1:0] w_word;
    logic [MAP_WORD_W-1:0] w_taken;
    logic [MAP_WORD_W-1:0] w_given;
    logic [BIT_IDX_W-1:0]  w_free_bit;
    logic [BIT_IDX_W-1:0]  w_give_bit;
    logic [SLOT_W-1:0]     w_new_id;
    logic                  w_map_we;
    logic [MAP_WORD_W-1:0] w_map_wd;
    logic                  w_slot_we;
    logic [SLOT_W-1:0]     w_slot_wa;
    logic [ITEM_WIDTH-1:0] w_slot_wd;

    assign w_cnt_dec = r_count - CW'(1);
    assign w_top     = r_cache[w_cnt_dec[IW-1:0]];

    // bitmap: lowest word not yet full, or the word of the id given back
    assign w_rd_widx = i_cmd.take_rd ? first_zero(r_full)
                                     : r_id[SLOT_W-1:BIT_IDX_W];

    // a word never written reads as all free; id 0 stays reserved
    always_comb begin
        w_word = r_wvalid[r_widx] ? w_map_q : '0;
        if (r_widx == '0) begin
            w_word[0] = 1'b1;
        end
    end

    assign w_free_bit = first_zero(w_word);
    assign w_give_bit = r_id[BIT_IDX_W-1:0];
    assign w_taken    = w_word | (MAP_WORD_W'(1) << w_free_bit);
    assign w_given    = w_word & ~(MAP_WORD_W'(1) << w_give_bit);
    assign w_new_id   = {r_widx, w_free_bit};
    assign w_map_we   = i_cmd.take_wr | i_cmd.give_wr;
    assign w_map_wd   = i_cmd.take_wr ? w_taken : w_given;

    csa_ram #(
        .WIDTH (MAP_WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_map_we),
        .i_wr_addr (r_widx),
        .i_wr_data (w_map_wd),
        .i_rd_en   (i_cmd.take_rd | i_cmd.give_rd),
        .i_rd_addr (w_rd_widx),
        .o_rd_data (w_map_q)
    );

    // slot table is written only: clearing pass, wipe on remove, store on add
    assign w_slot_we = i_cmd.clr_step | i_cmd.wipe | i_cmd.pop;
    assign w_slot_wa = i_cmd.clr_step ? r_clr : (i_cmd.wipe ? r_slot : w_top);
    assign w_slot_wd = i_cmd.pop ? r_item : '0;

    csa_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_slot_we),
        .i_wr_addr (w_slot_wa),
        .i_wr_data (w_slot_wd),
        .i_rd_en   (1'b0),
        .i_rd_addr ('0),
        .o_rd_data ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_full   <= '0;
            r_wvalid <= '0;
            r_clr    <= '0;
            o_done   <= 1'b0;
        end else begin
            o_done <= i_cmd.fin;
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + SLOT_W'(1);
            end
            if (i_cmd.take_wr) begin
                r_count                   <= r_count + CW'(1);
                r_full[r_widx]            <= &w_taken;
                r_wvalid[r_widx]          <= 1'b1;
            end
            if (i_cmd.give_wr) begin
                r_count          <= w_cnt_dec;
                r_full[r_widx]   <= 1'b0;
                r_wvalid[r_widx] <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_count <= w_cnt_dec;
            end
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_action <= i_action;
            r_item   <= i_item_value;
            r_slot   <= i_slot_index;
            r_id     <= i_slot_index;
        end
        if (i_cmd.take_rd | i_cmd.give_rd) begin
            r_widx <= w_rd_widx;
        end
        if (i_cmd.take_wr) begin
            r_cache[r_count[IW-1:0]] <= w_new_id;
        end
        if (i_cmd.push) begin
            r_cache[r_count[IW-1:0]] <= r_id;
        end
        if (i_cmd.give_wr) begin
            r_id <= w_top;
        end
        if (i_cmd.fin) begin
            o_status   <= i_cmd.fin_code;
            o_slot_out <= i_cmd.pop ? w_top : '0;
        end
    end

    assign o_stat.clr_last    = (r_clr == {SLOT_W{1'b1}});
    assign o_stat.is_add      = (r_action == ACT_ADD);
    assign o_stat.slot_zero   = (r_slot == '0);
    assign o_stat.cnt_zero    = (r_count == '0);
    assign o_stat.cnt_full    = (r_count >= CW'(CACHE_DEPTH));
    assign o_stat.refill_more = (r_count <= CW'(CACHE_DEPTH / 2));
    assign o_stat.drain_more  = (r_count >= CW'(CACHE_DEPTH / 2));
    assign o_stat.map_full    = &r_full;

endmodule
`default_nettype wire
